// File: rtl/mmtb_pkg.sv
`default_nettype none

package mmtb_pkg;

   localparam int DefChannels = 16;
   localparam int TimeW       = 32;
   localparam int SlotW       = 4;
   localparam int FuncW       = 3;
   localparam int KindW       = 3;
   localparam int ModeW       = 2;

   typedef enum logic [FuncW-1:0] {
      FUNC_TICK     = 3'd0,
      FUNC_ALLOC    = 3'd1,
      FUNC_PERIODIC = 3'd2,
      FUNC_SHOTS    = 3'd3,
      FUNC_STOP     = 3'd4,
      FUNC_CONTINUE = 3'd5,
      FUNC_RESTART  = 3'd6,
      FUNC_SET_ID   = 3'd7
   } func_type;

   typedef enum logic [KindW-1:0] {
      KIND_FIRED   = 3'd0,
      KIND_DONE    = 3'd1,
      KIND_GRANTED = 3'd2,
      KIND_FULL    = 3'd3,
      KIND_CMD     = 3'd4
   } kind_type;

   typedef enum logic [ModeW-1:0] {
      MODE_STOP     = 2'd0,
      MODE_PERIODIC = 2'd1,
      MODE_SHOTS    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DONE
   } state_type;

   typedef struct packed {
      mode_type               run_mode;
      mode_type               saved_mode;
      logic [TimeW-1:0]       reload_period;
      logic [TimeW-1:0]       remaining_time;
      logic [TimeW-1:0]       shots_left;
      logic [TimeW-1:0]       shots_saved;
      logic [TimeW-1:0]       stored_id;
   } chan_rec_type;

endpackage

`default_nettype wire

// File: rtl/mmtb_chan_update.sv
`default_nettype none

module mmtb_chan_update
   import mmtb_pkg::*;
(
   input  wire func_type          func,
   input  wire chan_rec_type      rec_in,
   input  wire logic [TimeW-1:0]  period,
   input  wire logic [TimeW-1:0]  shot_count,
   input  wire logic [TimeW-1:0]  delta,
   input  wire logic [TimeW-1:0]  event_id,
   output chan_rec_type           rec_out,
   output logic                   fire
);

   logic [TimeW:0]   diff;
   logic             expire;
   logic [TimeW-1:0] shots_dec;

   // shared subtractor: borrow or zero difference means remaining <= delta
   assign diff      = {1'b0, rec_in.remaining_time} - {1'b0, delta};
   assign expire    = diff[TimeW] || (diff[TimeW-1:0] == '0);
   assign shots_dec = (rec_in.shots_left != '0) ? rec_in.shots_left - TimeW'(1)
                                                : rec_in.shots_left;

   always_comb begin
      rec_out = rec_in;
      fire    = 1'b0;
      case (func)
         FUNC_TICK: begin
            if (rec_in.run_mode != MODE_STOP) begin
               if (rec_in.reload_period == '0) begin
                  rec_out.run_mode = MODE_STOP;
               end else if (!expire) begin
                  rec_out.remaining_time = diff[TimeW-1:0];
               end else begin
                  fire                   = 1'b1;
                  rec_out.remaining_time = rec_in.reload_period;
                  if (rec_in.run_mode == MODE_SHOTS) begin
                     rec_out.shots_left = shots_dec;
                     if (shots_dec == '0) begin
                        rec_out.run_mode = MODE_STOP;
                     end
                  end
               end
            end
         end
         FUNC_ALLOC: begin
            rec_out.run_mode = MODE_STOP;
         end
         FUNC_PERIODIC: begin
            rec_out.reload_period  = period;
            rec_out.remaining_time = period;
            rec_out.shots_left     = '0;
            rec_out.shots_saved    = '0;
            rec_out.saved_mode     = MODE_PERIODIC;
            rec_out.run_mode       = MODE_PERIODIC;
         end
         FUNC_SHOTS: begin
            rec_out.reload_period  = period;
            rec_out.remaining_time = period;
            rec_out.shots_left     = shot_count;
            rec_out.shots_saved    = shot_count;
            rec_out.saved_mode     = MODE_SHOTS;
            rec_out.run_mode       = MODE_SHOTS;
         end
         FUNC_STOP: begin
            rec_out.run_mode = MODE_STOP;
         end
         FUNC_CONTINUE: begin
            case (rec_in.saved_mode)
               MODE_PERIODIC: begin
                  rec_out.run_mode = MODE_PERIODIC;
               end
               MODE_SHOTS: begin
                  rec_out.shots_left = rec_in.shots_saved;
                  rec_out.run_mode   = MODE_SHOTS;
               end
               default: begin
                  rec_out.run_mode = rec_in.run_mode;
               end
            endcase
            rec_out.remaining_time = rec_in.reload_period;
         end
         FUNC_RESTART: begin
            rec_out.remaining_time = rec_in.reload_period;
         end
         default: begin
            rec_out.stored_id = event_id;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/multi_mode_timer_bank.sv
// A command passes the read and exec states and gives its single response from exec.
// A tick visits read and exec for each allocated channel, then done for the done response;
// per channel the record store gives one registered read, then update and write back.
// Throughput: one request at a time; the next is taken once the sequencer is idle,
// while the last response may still wait in the output register.
// Reset: synchronous; clears the allocation count and the per-channel valid bits.
`default_nettype none

module multi_mode_timer_bank
   import mmtb_pkg::*;
#(
   parameter int CHANNELS = DefChannels
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [FuncW-1:0]  req_func,
   input  wire logic [SlotW-1:0]  req_channel,
   input  wire logic [TimeW-1:0]  req_period,
   input  wire logic [TimeW-1:0]  req_shot_count,
   input  wire logic [TimeW-1:0]  req_delta,
   input  wire logic [TimeW-1:0]  req_event_id,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [KindW-1:0]       rsp_kind,
   output logic [SlotW-1:0]       rsp_slot,
   output logic [TimeW-1:0]       rsp_fired_id,
   output logic                   rsp_last
);

   localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CntW = $clog2(CHANNELS + 1);
   localparam int CmpW = (CntW > SlotW) ? CntW : SlotW;

   state_type           state_ff, state_in;
   func_type            func_ff;
   logic [SlotW-1:0]    chan_ff;
   logic [TimeW-1:0]    period_ff, count_ff, delta_ff, id_ff;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [CntW-1:0]     alloc_ff, alloc_in;

   chan_rec_type        mem_ff [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   chan_rec_type        rd_ff;
   logic                rd_valid_ff;
   chan_rec_type        rec_cur, rec_new;
   logic                fire;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [SlotW-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [TimeW-1:0]    rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept, out_free, out_load, mem_we, full, cmd_ok, last_chan;
   logic                needs_out, exec_go;
   func_type            req_func_t;

   assign req_func_t = func_type'(req_func);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign full       = (alloc_ff == CntW'(CHANNELS));
   assign cmd_ok     = (CmpW'(chan_ff) < CmpW'(alloc_ff));
   assign last_chan  = ((CntW'(idx_ff) + CntW'(1)) == alloc_ff);
   assign rec_cur    = rd_valid_ff ? rd_ff : '0;
   assign needs_out  = (func_ff != FUNC_TICK) || fire;
   assign exec_go    = !needs_out || out_free;

   mmtb_chan_update u_update (
      .func       (func_ff),
      .rec_in     (rec_cur),
      .period     (period_ff),
      .shot_count (count_ff),
      .delta      (delta_ff),
      .event_id   (id_ff),
      .rec_out    (rec_new),
      .fire       (fire)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func_t == FUNC_TICK && alloc_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go) begin
               if (func_ff != FUNC_TICK) begin
                  state_in = ST_IDLE;
               end else if (last_chan) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath controls
   always_comb begin
      req_ready   = 1'b0;
      idx_in      = idx_ff;
      alloc_in    = alloc_ff;
      mem_we      = 1'b0;
      out_load    = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            case (req_func_t)
               FUNC_TICK:  idx_in = '0;
               FUNC_ALLOC: idx_in = IdxW'(alloc_ff);
               default:    idx_in = IdxW'(req_channel);
            endcase
         end
         ST_EXEC: begin
            if (exec_go) begin
               out_load = needs_out;
               case (func_ff)
                  FUNC_TICK: begin
                     mem_we      = 1'b1;
                     idx_in      = idx_ff + IdxW'(1);
                     rsp_kind_in = KIND_FIRED;
                     rsp_slot_in = SlotW'(idx_ff);
                     rsp_id_in   = rec_cur.stored_id;
                     rsp_last_in = 1'b0;
                  end
                  FUNC_ALLOC: begin
                     mem_we      = !full;
                     rsp_id_in   = '0;
                     rsp_last_in = 1'b1;
                     if (full) begin
                        rsp_kind_in = KIND_FULL;
                        rsp_slot_in = '0;
                     end else begin
                        rsp_kind_in = KIND_GRANTED;
                        rsp_slot_in = SlotW'(alloc_ff);
                        alloc_in    = alloc_ff + CntW'(1);
                     end
                  end
                  default: begin
                     mem_we      = cmd_ok;
                     rsp_kind_in = KIND_CMD;
                     rsp_slot_in = chan_ff;
                     rsp_id_in   = '0;
                     rsp_last_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_kind_in = KIND_DONE;
               rsp_slot_in = '0;
               rsp_id_in   = '0;
               rsp_last_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alloc_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         if (mem_we) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // hold the request while it is worked on
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func_t;
         chan_ff   <= req_channel;
         period_ff <= req_period;
         count_ff  <= req_shot_count;
         delta_ff  <= req_delta;
         id_ff     <= req_event_id;
      end
      if (out_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_slot_ff <= rsp_slot_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // channel record store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[idx_ff] <= rec_new;
      end
      rd_ff       <= mem_ff[idx_ff];
      rd_valid_ff <= valid_ff[idx_ff];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire
